// ===== rtl/ccbb_pkg.sv =====
package ccbb_pkg;

	localparam int MAX_KNOTS = 64;
	localparam int ADDR_W    = $clog2(MAX_KNOTS);
	localparam int IDX_W     = ADDR_W + 1;

	localparam int KNOT_W     = 32;
	localparam int DUR_W      = KNOT_W + 1;
	localparam int EXT_W      = KNOT_W + 4;
	localparam int DELTA_W    = EXT_W;
	localparam int DEN_W      = DELTA_W + 1;
	localparam int WGT_W      = 17;
	localparam int FRAC_SHIFT = 32;
	localparam int TERM_W     = WGT_W + FRAC_SHIFT;

	localparam int OP_W  = 2;
	localparam int KPC_W = 6;
	localparam int COL_W = 6;

	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_EVAL    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_KNOTS_PER_CYCLE = 1'b0;

	localparam logic [KPC_W-1:0] KPC_RESET  = 6'd4;
	localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'h10000;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_ctl_t;

endpackage

// ===== rtl/ccbb_if.sv =====
interface ccbb_in_if;
	logic                               valid;
	logic                               ready;
	logic [ccbb_pkg::OP_W-1:0]          opcode;
	logic [ccbb_pkg::ADDR_W-1:0]        knot_index;
	logic signed [ccbb_pkg::KNOT_W-1:0] value;

	modport source(output valid, output opcode, output knot_index, output value, input ready);
	modport sink(input valid, input opcode, input knot_index, input value, output ready);
endinterface

interface ccbb_out_if;
	logic                         valid;
	logic                         ready;
	logic [ccbb_pkg::COL_W-1:0]   column;
	logic [ccbb_pkg::WGT_W-1:0]   weight;
	logic                         last;

	modport source(output valid, output column, output weight, output last, input ready);
	modport sink(input valid, input column, input weight, input last, output ready);
endinterface

// ===== rtl/cyclic_cubic_bspline_basis_core.sv =====
// Channel  | Dir | Payload                              | Item
// in       | in  | opcode, knot_index, value (Q16.16)   | knot write, sample or restart
// out      | out | column, weight (Q1.16), last         | one basis weight, four per sample
// APB      | in  | knots_per_cycle at byte address 0    | register write or read
//
// Knot writes and restarts complete without leaving the idle state. A sample runs setup, an
// interval search that advances one knot at a time and the knot fetches, then six de Boor steps
// (a division and two multiplies on the shared bit-serial unit; no division when the
// divisor is zero), then emits its four weights.
// The block is not ready from acceptance of a sample until its last weight is taken.
// A stalled output holds the current weight. Reset needs no clearing pass.
module cyclic_cubic_bspline_basis_core (
	input  logic                             clk,
	input  logic                             arst_n,
	ccbb_in_if.sink                          in,
	ccbb_out_if.source                       out,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ccbb_pkg::PADDR_W-1:0]     paddr,
	input  logic [ccbb_pkg::PDATA_W-1:0]     pwdata,
	output logic [ccbb_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);
	localparam int AW = ccbb_pkg::ADDR_W;
	localparam int IW = ccbb_pkg::IDX_W;
	localparam int KW = ccbb_pkg::KNOT_W;
	localparam int EW = ccbb_pkg::EXT_W;
	localparam int DW = ccbb_pkg::DELTA_W;
	localparam int WW = ccbb_pkg::WGT_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_T0     = 4'd1;
	localparam logic [3:0] S_TK     = 4'd2;
	localparam logic [3:0] S_DUR    = 4'd3;
	localparam logic [3:0] S_SRCH   = 4'd4;
	localparam logic [3:0] S_CMP    = 4'd5;
	localparam logic [3:0] S_FETCH  = 4'd6;
	localparam logic [3:0] S_LOAD   = 4'd7;
	localparam logic [3:0] S_CLAMP  = 4'd8;
	localparam logic [3:0] S_DELTA  = 4'd9;
	localparam logic [3:0] S_DSTART = 4'd10;
	localparam logic [3:0] S_DIV    = 4'd11;
	localparam logic [3:0] S_MR     = 4'd12;
	localparam logic [3:0] S_ML     = 4'd13;
	localparam logic [3:0] S_EMIT   = 4'd14;

	typedef struct packed {
		logic [AW-1:0]     addr;
		logic signed [2:0] n;
	} ext_ref_t;

	// Extended knot p maps to a table entry plus a multiple of the period.
	function automatic ext_ref_t ext_map(input logic [IW-1:0] p, input logic [IW-1:0] ks);
		logic [IW-1:0]     q;
		logic [IW-1:0]     a;
		logic signed [2:0] n;
		ext_ref_t          r;
		q = p;
		n = 3'sd0;
		if (p < IW'(2)) begin
			q = p + ks;
			n = -3'sd1;
			if (q < IW'(2)) begin
				q = q + ks;
				n = -3'sd2;
			end
		end else if (p > ks + IW'(2)) begin
			q = p - ks;
			n = 3'sd1;
			if (q > ks + IW'(2)) begin
				q = q - ks;
				n = 3'sd2;
			end
		end
		a = q - IW'(2);
		r.addr = a[AW-1:0];
		r.n = n;
		return r;
	endfunction

	logic [3:0]                    state_q;
	logic [ccbb_pkg::KPC_W-1:0]    kpc_q;
	logic [IW-1:0]                 interval_q;
	logic [IW-1:0]                 lft_q;
	logic signed [KW-1:0]          x_q;
	logic signed [KW-1:0]          t0_q;
	logic signed [ccbb_pkg::DUR_W-1:0] dur_q;
	logic [2:0]                    f_q;
	logic signed [2:0]             n_q;
	logic signed [EW-1:0]          e_q [6];
	logic signed [EW-1:0]          xc_q;
	logic [DW-1:0]                 dr_q [3];
	logic [DW-1:0]                 dl_q [3];
	logic [WW-1:0]                 w_q [4];
	logic [1:0]                    i_q;
	logic [1:0]                    j_q;
	logic [1:0]                    k_q;
	logic [WW-1:0]                 carry_q;
	logic [WW-1:0]                 nw_q;
	logic [ccbb_pkg::TERM_W-1:0]   term_q;
	logic [ccbb_pkg::COL_W-1:0]    col_q;

	logic [ccbb_pkg::KPC_W-1:0]    k_eff;
	logic [IW-1:0]                 ks;
	logic [IW-1:0]                 kp1;
	logic [IW-1:0]                 lft_init;
	logic [IW-1:0]                 p_fetch;
	logic [IW-1:0]                 lft_m1;
	ext_ref_t                      ref_fetch;
	logic [AW-1:0]                 raddr;
	logic [KW-1:0]                 rdata;
	logic signed [EW-1:0]          rdata_ext;
	logic signed [EW-1:0]          dur_ext;
	logic signed [EW-1:0]          ndur;
	logic signed [EW-1:0]          x_ext;
	logic signed [EW-1:0]          xc_new;
	logic [ccbb_pkg::DEN_W-1:0]    den;
	logic [DW-1:0]                 dr_sel;
	logic [DW-1:0]                 dl_sel;
	logic [1:0]                    w_idx;
	logic [WW-1:0]                 w_rd;
	logic [1:0]                    jmi;
	logic                          in_fire;
	logic                          out_fire;
	logic                          cfg_wr;
	ccbb_pkg::md_ctl_t             md_ctl;
	logic [ccbb_pkg::DELTA_W-1:0]  md_mplier;
	logic [ccbb_pkg::TERM_W-1:0]   md_mcand;
	logic                          md_done;
	logic [ccbb_pkg::TERM_W-1:0]   md_quot;
	logic [WW-1:0]                 md_prod;

	assign in_fire  = in.valid && in.ready;
	assign out_fire = out.valid && out.ready;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == ccbb_pkg::REG_KNOTS_PER_CYCLE);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ccbb_pkg::REG_KNOTS_PER_CYCLE) ?
		{{(ccbb_pkg::PDATA_W-ccbb_pkg::KPC_W){1'b0}}, kpc_q} : '0;

	assign k_eff    = (kpc_q == '0) ? ccbb_pkg::KPC_W'(1) : kpc_q;
	assign ks       = IW'(k_eff);
	assign kp1      = ks + IW'(1);
	assign lft_init = (interval_q < IW'(2)) ? IW'(2) : ((interval_q > kp1) ? kp1 : interval_q);
	assign lft_m1   = lft_q - IW'(1);
	assign p_fetch  = lft_q - IW'(2) + IW'(f_q);
	assign ref_fetch = ext_map(p_fetch, ks);

	always_comb begin
		unique case (state_q)
			S_TK:    raddr = k_eff;
			S_SRCH:  raddr = lft_m1[AW-1:0];
			S_FETCH: raddr = ref_fetch.addr;
			default: raddr = '0;
		endcase
	end

	ccbb_ram #(.WIDTH(KW), .DEPTH(ccbb_pkg::MAX_KNOTS)) u_knots (
		.clk   (clk),
		.we    (in_fire && (in.opcode == ccbb_pkg::OP_WRITE)),
		.waddr (in.knot_index),
		.wdata (in.value),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rdata_ext = {{(EW-KW){rdata[KW-1]}}, rdata};
	assign dur_ext   = {{(EW-ccbb_pkg::DUR_W){dur_q[ccbb_pkg::DUR_W-1]}}, dur_q};
	assign x_ext     = {{(EW-KW){x_q[KW-1]}}, x_q};

	always_comb begin
		unique case (n_q)
			-3'sd2:  ndur = -(dur_ext <<< 1);
			-3'sd1:  ndur = -dur_ext;
			3'sd1:   ndur = dur_ext;
			3'sd2:   ndur = dur_ext <<< 1;
			default: ndur = '0;
		endcase
	end

	// The later lower clamp wins when the interval is inverted.
	always_comb begin
		xc_new = x_ext;
		if (xc_new > e_q[3]) begin
			xc_new = e_q[3];
		end
		if (xc_new < e_q[2]) begin
			xc_new = e_q[2];
		end
	end

	assign jmi    = j_q - i_q;
	assign dr_sel = dr_q[i_q];
	assign dl_sel = dl_q[jmi];
	assign den    = {1'b0, dr_sel} + {1'b0, dl_sel};
	assign w_idx  = (state_q == S_EMIT) ? k_q : i_q;
	assign w_rd   = w_q[w_idx];

	always_comb begin
		md_ctl.start  = 1'b0;
		md_ctl.is_div = 1'b0;
		unique case (state_q)
			S_DSTART: begin
				md_ctl.start  = 1'b1;
				md_ctl.is_div = (den != '0);
			end
			S_DIV, S_MR: md_ctl.start = md_done;
			default: md_ctl.start = 1'b0;
		endcase
	end

	assign md_mplier = (state_q == S_MR) ? dl_sel : dr_sel;
	assign md_mcand  = (state_q == S_DIV) ? md_quot :
		((state_q == S_DSTART) ? '0 : term_q);

	ccbb_muldiv u_muldiv (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (md_ctl),
		.dividend_w (w_rd),
		.divisor    (den),
		.mplier     (md_mplier),
		.mcand      (md_mcand),
		.done       (md_done),
		.quotient   (md_quot),
		.product    (md_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kpc_q      <= ccbb_pkg::KPC_RESET;
			interval_q <= IW'(2);
			lft_q      <= IW'(2);
			f_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
		end else begin
			if (cfg_wr) begin
				kpc_q <= pwdata[ccbb_pkg::KPC_W-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in.opcode == ccbb_pkg::OP_EVAL) begin
							state_q <= S_T0;
						end else if (in.opcode == ccbb_pkg::OP_RESTART) begin
							interval_q <= IW'(2);
						end
					end
				end
				S_T0:  state_q <= S_TK;
				S_TK:  state_q <= S_DUR;
				S_DUR: begin
					lft_q   <= lft_init;
					f_q     <= '0;
					state_q <= S_SRCH;
				end
				S_SRCH: state_q <= (lft_q < kp1) ? S_CMP : S_FETCH;
				S_CMP: begin
					if (x_q > $signed(rdata)) begin
						lft_q   <= lft_q + IW'(1);
						state_q <= S_SRCH;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_LOAD;
				S_LOAD: begin
					if (f_q == 3'd5) begin
						state_q <= S_CLAMP;
					end else begin
						f_q     <= f_q + 3'd1;
						state_q <= S_FETCH;
					end
				end
				S_CLAMP: begin
					interval_q <= lft_q;
					state_q    <= S_DELTA;
				end
				S_DELTA: begin
					i_q     <= '0;
					j_q     <= '0;
					state_q <= S_DSTART;
				end
				S_DSTART: state_q <= (den != '0) ? S_DIV : S_MR;
				S_DIV: begin
					if (md_done) begin
						state_q <= S_MR;
					end
				end
				S_MR: begin
					if (md_done) begin
						state_q <= S_ML;
					end
				end
				S_ML: begin
					if (md_done) begin
						if (i_q == j_q) begin
							i_q <= '0;
							if (j_q == 2'd2) begin
								k_q     <= '0;
								state_q <= S_EMIT;
							end else begin
								j_q     <= j_q + 2'd1;
								state_q <= S_DSTART;
							end
						end else begin
							i_q     <= i_q + 2'd1;
							state_q <= S_DSTART;
						end
					end
				end
				S_EMIT: begin
					if (out_fire) begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= in.value;
		end
		unique case (state_q)
			S_TK:  t0_q <= rdata;
			S_DUR: dur_q <= {rdata[KW-1], rdata} - {t0_q[KW-1], t0_q};
			S_FETCH: n_q <= ref_fetch.n;
			S_LOAD: e_q[f_q] <= rdata_ext + ndur;
			S_CLAMP: xc_q <= xc_new;
			S_DELTA: begin
				for (int m = 0; m < 3; m++) begin
					logic signed [EW:0] dpos;
					logic signed [EW:0] dneg;
					dpos = {e_q[3+m][EW-1], e_q[3+m]} - {xc_q[EW-1], xc_q};
					dneg = {xc_q[EW-1], xc_q} - {e_q[2-m][EW-1], e_q[2-m]};
					dr_q[m] <= dpos[EW] ? '0 : dpos[DW-1:0];
					dl_q[m] <= dneg[EW] ? '0 : dneg[DW-1:0];
				end
				w_q[0]  <= ccbb_pkg::WEIGHT_ONE;
				carry_q <= '0;
			end
			S_DSTART: begin
				if (den == '0) begin
					term_q <= '0;
				end
			end
			S_DIV: begin
				if (md_done) begin
					term_q <= md_quot;
				end
			end
			S_MR: begin
				if (md_done) begin
					nw_q <= carry_q + md_prod;
				end
			end
			S_ML: begin
				if (md_done) begin
					w_q[i_q] <= nw_q;
					if (i_q == j_q) begin
						w_q[j_q + 2'd1] <= md_prod;
						carry_q         <= '0;
						col_q           <= ccbb_pkg::COL_W'(lft_q - IW'(2));
					end else begin
						carry_q <= md_prod;
					end
				end
			end
			S_EMIT: begin
				if (out_fire) begin
					col_q <= (col_q + ccbb_pkg::COL_W'(1) == k_eff) ? '0 :
						col_q + ccbb_pkg::COL_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign in.ready   = (state_q == S_IDLE);
	assign out.valid  = (state_q == S_EMIT);
	assign out.column = col_q;
	assign out.weight = (w_rd > ccbb_pkg::WEIGHT_ONE) ? ccbb_pkg::WEIGHT_ONE : w_rd;
	assign out.last   = (k_q == 2'd3);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> !in.ready)
		else $error("result offered while input is open");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in.opcode == ccbb_pkg::OP_EVAL)) |=> !in.ready)
		else $error("sample did not start the sequencer");

	a_interval_range: assert property (@(posedge clk) disable iff (!arst_n)
		(interval_q >= IW'(2)) && (interval_q <= IW'(ccbb_pkg::MAX_KNOTS)))
		else $error("interval index out of range");
endmodule

// ===== rtl/ccbb_ram.sv =====
module ccbb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/ccbb_muldiv.sv =====
module ccbb_muldiv (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ccbb_pkg::md_ctl_t              ctl,
	input  logic [ccbb_pkg::WGT_W-1:0]     dividend_w,
	input  logic [ccbb_pkg::DEN_W-1:0]     divisor,
	input  logic [ccbb_pkg::DELTA_W-1:0]   mplier,
	input  logic [ccbb_pkg::TERM_W-1:0]    mcand,
	output logic                           done,
	output logic [ccbb_pkg::TERM_W-1:0]    quotient,
	output logic [ccbb_pkg::WGT_W-1:0]     product
);
	localparam int TW = ccbb_pkg::TERM_W;
	localparam int DW = ccbb_pkg::DEN_W;
	localparam int MW = ccbb_pkg::DELTA_W;
	localparam int FS = ccbb_pkg::FRAC_SHIFT;
	localparam int PH = ccbb_pkg::WGT_W + FS - MW;
	localparam int CNT_W = $clog2(TW);

	logic [TW-1:0]    acc_q;
	logic [TW-1:0]    sh_q;
	logic [TW-1:0]    op_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             div_q;
	logic             done_q;

	logic [DW:0]   trial;
	logic [DW+1:0] diff;
	logic          borrow;
	logic [TW:0]   sum;

	// Restoring division brings in one dividend bit per cycle; the multiply
	// adds the multiplicand under each multiplier bit, lowest bit first.
	assign trial  = {acc_q[DW-1:0], sh_q[TW-1]};
	assign diff   = {1'b0, trial} - {2'b0, op_q[DW-1:0]};
	assign borrow = diff[DW+1];
	assign sum    = {1'b0, acc_q} + (sh_q[0] ? {1'b0, op_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (ctl.start) begin
				busy_q <= 1'b1;
				div_q  <= ctl.is_div;
				cnt_q  <= ctl.is_div ? CNT_W'(TW - 1) : CNT_W'(MW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			if (ctl.is_div) begin
				sh_q <= {dividend_w, {FS{1'b0}}};
				op_q <= {{(TW-DW){1'b0}}, divisor};
			end else begin
				sh_q <= {{(TW-MW){1'b0}}, mplier};
				op_q <= mcand;
			end
		end else if (busy_q) begin
			if (div_q) begin
				acc_q <= {{(TW-DW){1'b0}}, borrow ? trial[DW-1:0] : diff[DW-1:0]};
				sh_q  <= {sh_q[TW-2:0], ~borrow};
			end else begin
				acc_q <= sum[TW:1];
				sh_q  <= {{(TW-MW){1'b0}}, sum[0], sh_q[MW-1:1]};
			end
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;
	assign product  = {acc_q[PH-1:0], sh_q[MW-1:FS]};
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam logic [ccbb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 1500;
	localparam int IDLE_LIMIT  = 8000;

	typedef struct packed {
		logic [ccbb_pkg::COL_W-1:0] column;
		logic [ccbb_pkg::WGT_W-1:0] weight;
		logic                       last;
	} basis_weight_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ccbb_pkg::PADDR_W-1:0] paddr;
	logic [ccbb_pkg::PDATA_W-1:0] pwdata;
	logic [ccbb_pkg::PDATA_W-1:0] prdata;
	logic pready;

	ccbb_in_if  in_ch ();
	ccbb_out_if out_ch ();

	cyclic_cubic_bspline_basis_core u_top (
		.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow state of the block.
	logic signed [ccbb_pkg::KNOT_W-1:0] knot_shadow [ccbb_pkg::MAX_KNOTS];
	int unsigned                        interval_shadow;
	logic [ccbb_pkg::KPC_W-1:0]         kpc_shadow;

	basis_weight_t weights_due [$];
	int  errors;
	int  items_sent;
	bit  burst_mode;
	bit  hold_req;
	int  idle_count;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint unsigned clip_neg(longint v);
		return (v < 0) ? 64'd0 : longint'(v);
	endfunction

	task automatic predict_weights(logic signed [ccbb_pkg::KNOT_W-1:0] x_in);
		longint ext [ccbb_pkg::MAX_KNOTS + 4];
		longint unsigned dr [3];
		longint unsigned dl [3];
		longint unsigned w [4];
		longint unsigned carry, den, term, nw, wt;
		longint dur, x, xc;
		int unsigned k, lft, ic;
		basis_weight_t r;
		k = kpc_shadow;
		if (k < 1)
			k = 1;
		x = longint'(x_in);
		for (int m = 0; m <= k; m++)
			ext[m + 2] = longint'(knot_shadow[m]);
		dur = ext[k + 2] - ext[2];
		ext[1] = ext[k + 1] - dur;
		ext[0] = ext[k] - dur;
		ext[k + 3] = ext[3] + dur;
		ext[k + 4] = ext[4] + dur;
		lft = interval_shadow;
		if (lft < 2)
			lft = 2;
		if (lft > k + 1)
			lft = k + 1;
		while (lft < k + 1 && x > ext[lft + 1])
			lft++;
		interval_shadow = lft;
		xc = x;
		if (xc > ext[lft + 1])
			xc = ext[lft + 1];
		if (xc < ext[lft])
			xc = ext[lft];
		w[0] = 64'd65536;
		for (int j = 0; j < 3; j++) begin
			carry = 0;
			dr[j] = clip_neg(ext[lft + j + 1] - xc);
			dl[j] = clip_neg(xc - ext[lft - j]);
			for (int i = 0; i <= j; i++) begin
				den  = dr[i] + dl[j - i];
				term = (den != 0) ? (w[i] << 32) / den : 64'd0;
				nw    = carry + ((dr[i] * term) >> 32);
				carry = (dl[j - i] * term) >> 32;
				w[i]  = nw;
			end
			w[j + 1] = carry;
		end
		ic = (lft - 2) % k;
		for (int i = 0; i < 4; i++) begin
			wt = (w[i] > 64'd65536) ? 64'd65536 : w[i];
			r.column = ccbb_pkg::COL_W'((ic + i) % k);
			r.weight = ccbb_pkg::WGT_W'(wt);
			r.last   = (i == 3);
			weights_due = {weights_due, r};
		end
	endtask

	task automatic send_item(logic [ccbb_pkg::OP_W-1:0] op,
			logic [ccbb_pkg::ADDR_W-1:0] idx, logic [ccbb_pkg::KNOT_W-1:0] val);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.opcode     <= op;
		in_ch.knot_index <= idx;
		in_ch.value      <= val;
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
		items_sent++;
		case (op)
			ccbb_pkg::OP_WRITE: begin
				knot_shadow[idx] = val;
			end
			ccbb_pkg::OP_RESTART: begin
				interval_shadow = 2;
			end
			ccbb_pkg::OP_EVAL: begin
				predict_weights(val);
			end
			default: ;
		endcase
	endtask

	task automatic finish_sending();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_kpc(logic [ccbb_pkg::KPC_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ccbb_pkg::PADDR_W'(4 * int'(ccbb_pkg::REG_KNOTS_PER_CYCLE));
		pwdata  <= ccbb_pkg::PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		kpc_shadow = v;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[ccbb_pkg::KPC_W-1:0] !== v) begin
			$error("knots_per_cycle readback: expected %0d, actual %0d", v,
				prdata[ccbb_pkg::KPC_W-1:0]);
			errors++;
		end
		if (pready !== 1'b1) begin
			$error("pready: expected 1, actual %0b", pready);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Lets the queue drain, then gives a write or restart time to settle.
	task automatic wait_idle();
		finish_sending();
		while (weights_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Loads knots 0..k with random spacing, ascending unless shuffle is set, sometimes coincident.
	task automatic load_knots(int unsigned k, bit shuffle);
		logic [ccbb_pkg::KNOT_W-1:0] pos;
		pos = ccbb_pkg::KNOT_W'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
		for (int m = 0; m <= k; m++) begin
			send_item(ccbb_pkg::OP_WRITE, ccbb_pkg::ADDR_W'(m), pos);
			if (shuffle && $urandom_range(0, 3) == 0)
				pos = pos - ccbb_pkg::KNOT_W'($urandom_range(0, 32'h0002_0000));
			else if ($urandom_range(0, 9) == 0)
				pos = pos;
			else
				pos = pos + ccbb_pkg::KNOT_W'($urandom_range(1, 32'h0003_0000));
		end
	endtask

	// Ascending samples over the table with some noise mixed in.
	task automatic sweep_samples(int unsigned k, int count);
		logic signed [ccbb_pkg::KNOT_W-1:0] x, span;
		logic [ccbb_pkg::ADDR_W-1:0] stray;
		int pick;
		span = knot_shadow[k] - knot_shadow[0];
		x = knot_shadow[0] - ccbb_pkg::KNOT_W'($urandom_range(0, 32'h0001_0000));
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				send_item(ccbb_pkg::OP_EVAL, ccbb_pkg::ADDR_W'($urandom), x);
				x = x + ccbb_pkg::KNOT_W'($urandom_range(0,
					(span > 0 ? span : 32'h10000) / (count / 2 + 1)));
			end else if (pick < 90) begin
				send_item(ccbb_pkg::OP_EVAL, ccbb_pkg::ADDR_W'($urandom),
					ccbb_pkg::KNOT_W'($urandom));
			end else if (pick < 94) begin
				send_item(ccbb_pkg::OP_RESTART, ccbb_pkg::ADDR_W'($urandom),
					ccbb_pkg::KNOT_W'($urandom));
				x = knot_shadow[0];
			end else if (pick < 97 || k == ccbb_pkg::MAX_KNOTS - 1) begin
				send_item(OP_UNUSED, ccbb_pkg::ADDR_W'($urandom), ccbb_pkg::KNOT_W'($urandom));
			end else begin
				stray = ccbb_pkg::ADDR_W'($urandom_range(k + 1, ccbb_pkg::MAX_KNOTS - 1));
				send_item(ccbb_pkg::OP_WRITE, stray, ccbb_pkg::KNOT_W'($urandom));
			end
		end
	endtask

	task automatic test_directed();
		for (int m = 0; m <= 4; m++)
			send_item(ccbb_pkg::OP_WRITE, ccbb_pkg::ADDR_W'(m), ccbb_pkg::KNOT_W'(m) << 16);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h0000_0000);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h0000_8000);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h0001_0000);
		send_item(ccbb_pkg::OP_EVAL, '1, 32'h0002_B333);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h0000_4CCC);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h0004_0000);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h0009_0000);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h7FFF_FFFF);
		send_item(OP_UNUSED, '1, 32'hFFFF_FFFF);
		send_item(ccbb_pkg::OP_RESTART, '0, '0);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'hFFFB_0000);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h8000_0000);
		// Unordered and coincident knots exercise clipped deltas and zero divisors.
		send_item(ccbb_pkg::OP_WRITE, 6'd2, 32'h0000_8000);
		send_item(ccbb_pkg::OP_WRITE, 6'd3, 32'h0004_0000);
		send_item(ccbb_pkg::OP_RESTART, '0, '0);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h0000_C000);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h0003_8000);
		// Knots at the extremes of the value range.
		send_item(ccbb_pkg::OP_WRITE, 6'd0, 32'h8000_0000);
		send_item(ccbb_pkg::OP_WRITE, 6'd4, 32'h7FFF_FFFF);
		send_item(ccbb_pkg::OP_WRITE, 6'd63, 32'h5A5A_A5A5);
		send_item(ccbb_pkg::OP_RESTART, '0, '0);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'hC000_0000);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h4000_0000);
		wait_idle();
	endtask

	task automatic test_extreme_configs();
		write_kpc(6'd63);
		load_knots(63, 1'b0);
		send_item(ccbb_pkg::OP_RESTART, '0, '0);
		sweep_samples(63, 24);
		// Drive the index to the last interval so a later shrink leaves it stale.
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h7FFF_FFFF);
		wait_idle();
		write_kpc(6'd0);
		load_knots(1, 1'b0);
		sweep_samples(1, 10);
		wait_idle();
		write_kpc(6'd1);
		load_knots(1, 1'b0);
		send_item(ccbb_pkg::OP_RESTART, '0, '0);
		sweep_samples(1, 8);
		wait_idle();
	endtask

	task automatic test_shrink_stale();
		write_kpc(6'd63);
		load_knots(63, 1'b0);
		send_item(ccbb_pkg::OP_EVAL, '0, 32'h7FFF_FFFF);
		wait_idle();
		write_kpc(6'd5);
		send_item(ccbb_pkg::OP_EVAL, '0, knot_shadow[2]);
		send_item(ccbb_pkg::OP_EVAL, '0, knot_shadow[5]);
		wait_idle();
	endtask

	task automatic test_backpressure();
		write_kpc(6'd6);
		load_knots(6, 1'b0);
		send_item(ccbb_pkg::OP_RESTART, '0, '0);
		hold_req = 1'b1;
		burst_mode = 1'b1;
		sweep_samples(6, 8);
		burst_mode = 1'b0;
		wait_idle();
	endtask

	task automatic test_random_sweeps();
		int unsigned k;
		while (items_sent < 280) begin
			k = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
			write_kpc(ccbb_pkg::KPC_W'(k));
			load_knots(k, $urandom_range(0, 4) == 0);
			send_item(ccbb_pkg::OP_RESTART, '0, '0);
			burst_mode = ($urandom_range(0, 2) == 0);
			sweep_samples(k, $urandom_range(8, 20));
			burst_mode = 1'b0;
			wait_idle();
		end
	endtask

	// Result side: random stalls, a long hold on request, compare against the queue.
	initial begin
		basis_weight_t got, want;
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = burst_mode ? 0 : $urandom_range(0, 16);
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(negedge clk); while (!out_ch.valid);
			got.column = out_ch.column;
			got.weight = out_ch.weight;
			got.last   = out_ch.last;
			@(posedge clk);
			if (weights_due.size() == 0) begin
				$error("unexpected item: column %0d weight %0d last %0b",
					got.column, got.weight, got.last);
				errors++;
			end else begin
				want = weights_due.pop_front();
				if (got.column !== want.column) begin
					$error("column: expected %0d, actual %0d", want.column, got.column);
					errors++;
				end
				if (got.weight !== want.weight) begin
					$error("weight: expected %0d, actual %0d", want.weight, got.weight);
					errors++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, got.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = ccbb_pkg::OP_WRITE;
		in_ch.knot_index = '0;
		in_ch.value = '0;
		errors = 0;
		items_sent = 0;
		burst_mode = 1'b0;
		hold_req = 1'b0;
		idle_count = 0;
		interval_shadow = 2;
		kpc_shadow = ccbb_pkg::KPC_RESET;
		for (int m = 0; m < ccbb_pkg::MAX_KNOTS; m++)
			knot_shadow[m] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_extreme_configs();
		test_shrink_stale();
		test_backpressure();
		test_random_sweeps();
		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0 && weights_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
